>>> hw/rtl/plq_pkg.sv
package plq_pkg;

   // Store geometry.
   localparam int DEPTH    = 64;
   localparam int QTY_BITS = 32;

   // Field widths of the command and response.
   localparam int KEY_W       = 64;
   localparam int QTY_W       = 32;
   localparam int TOTAL_W     = 38;
   localparam int LEVEL_CNT_W = 7;

   // The resting count must be able to hold DEPTH itself.
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Quantities are cut to QTY_BITS before they are stored or summed.
   localparam logic [QTY_W-1:0] QTY_MASK =
      (QTY_BITS >= QTY_W) ? {QTY_W{1'b1}} : QTY_W'((64'd1 << QTY_BITS) - 64'd1);

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef struct packed {
      logic             opcode;
      logic [KEY_W-1:0] order_key;
      logic [QTY_W-1:0] order_qty;
   } plq_req_type;

   typedef struct packed {
      status_type             status;
      logic [KEY_W-1:0]       removed_key;
      logic [QTY_W-1:0]       removed_qty;
      logic [TOTAL_W-1:0]     level_total;
      logic [LEVEL_CNT_W-1:0] level_count;
   } plq_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic compare;
      logic apply;
   } plq_cmd_type;

endpackage

>>> hw/rtl/plq_ctrl.sv
module plq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   output plq_pkg::plq_cmd_type cmd
);
   import plq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE    = 3'b001,
      S_COMPARE = 3'b010,
      S_APPLY   = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      accept;

   // A new command may enter while the previous one is being applied.
   assign busy   = (state_ff == S_COMPARE);
   assign accept = start && !busy;

   assign cmd.load    = accept;
   assign cmd.compare = (state_ff == S_COMPARE);
   assign cmd.apply   = (state_ff == S_APPLY);

   always_comb begin
      unique case (state_ff)
         S_IDLE:    state_in = accept ? S_COMPARE : S_IDLE;
         S_COMPARE: state_in = S_APPLY;
         S_APPLY:   state_in = accept ? S_COMPARE : S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.apply;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/plq_dpath.sv
module plq_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  plq_pkg::plq_cmd_type cmd,
   input  plq_pkg::plq_req_type req_data,
   output plq_pkg::plq_rsp_type rsp_data
);
   import plq_pkg::*;

   plq_req_type        req_ff;
   logic [KEY_W-1:0]   key_ff [DEPTH];
   logic [QTY_W-1:0]   qty_ff [DEPTH];
   logic [DEPTH-1:0]   match_ff;
   logic [DEPTH-1:0]   match_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W-1:0] total_in;
   plq_rsp_type        rsp_ff;
   plq_rsp_type        rsp_in;

   logic [DEPTH-1:0]   first_hit;
   logic [DEPTH-1:0]   below_hit;
   logic               found;
   logic               is_add;
   logic               full;
   logic               do_add;
   logic               do_remove;
   logic [QTY_W-1:0]   add_qty;
   logic [QTY_W-1:0]   hit_qty;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   // One comparator per entry; entries at or above the count never match.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cmp
      assign match_in[g] = (key_ff[g] == req_ff.order_key) && (CNT_W'(g) < count_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         match_ff <= match_in;
      end
   end

   // The oldest match is the lowest set bit; entries below it stay put.
   assign found     = |match_ff;
   assign first_hit = match_ff & (~match_ff + DEPTH'(1));
   assign below_hit = first_hit - DEPTH'(1);

   always_comb begin
      hit_qty = '0;
      for (int i = 0; i < DEPTH; i++) begin
         hit_qty = hit_qty | (qty_ff[i] & {QTY_W{first_hit[i]}});
      end
   end

   assign is_add    = (req_ff.opcode == OP_ADD);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign do_add    = cmd.apply && is_add && !full;
   assign do_remove = cmd.apply && !is_add && found;
   assign add_qty   = req_ff.order_qty & QTY_MASK;

   always_comb begin
      count_in           = count_ff;
      total_in           = total_ff;
      rsp_in.status      = ST_DONE;
      rsp_in.removed_key = '0;
      rsp_in.removed_qty = '0;
      priority if (is_add && full) begin
         rsp_in.status = ST_FULL;
      end else if (is_add) begin
         count_in = count_ff + CNT_W'(1);
         total_in = total_ff + TOTAL_W'(add_qty);
      end else if (found) begin
         count_in           = count_ff - CNT_W'(1);
         total_in           = total_ff - TOTAL_W'(hit_qty);
         rsp_in.removed_key = req_ff.order_key;
         rsp_in.removed_qty = hit_qty;
      end else begin
         rsp_in.status = ST_NOT_FOUND;
      end
      rsp_in.level_total = total_in;
      rsp_in.level_count = LEVEL_CNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         total_ff <= '0;
      end else if (cmd.apply) begin
         count_ff <= count_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         rsp_ff <= rsp_in;
      end
   end

   // Each entry is written at the tail on an add; every entry but the last also
   // takes its younger neighbor when a remove closes the gap at or below it.
   for (genvar g = 0; g < DEPTH; g++) begin : g_entry
      if (g < DEPTH - 1) begin : g_shift
         always_ff @(posedge clock) begin
            if (do_add && (CNT_W'(g) == count_ff)) begin
               key_ff[g] <= req_ff.order_key;
               qty_ff[g] <= add_qty;
            end else if (do_remove && !below_hit[g]) begin
               key_ff[g] <= key_ff[g+1];
               qty_ff[g] <= qty_ff[g+1];
            end
         end
      end else begin : g_last
         always_ff @(posedge clock) begin
            if (do_add && (CNT_W'(g) == count_ff)) begin
               key_ff[g] <= req_ff.order_key;
               qty_ff[g] <= add_qty;
            end
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> hw/rtl/price_level_order_queue.sv
// A command passes through a compare cycle, where the request key is compared
// with every entry in parallel and the matches are registered, and an apply
// cycle, where the entries shift one place or take the new tail and the
// result is registered with its strobe. A new command may enter during apply.
// Reset (synchronous, active high) empties the queue and clears the total;
// the receiver cannot stall, so every result is shown for exactly one cycle.
module price_level_order_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  plq_pkg::plq_req_type req_data,
   output logic                 rsp_valid,
   output plq_pkg::plq_rsp_type rsp_data
);
   import plq_pkg::*;

   // Command signals from the controller to the datapath. A transfer is
   // captured when start is high and busy is low; busy is high only in the
   // compare cycle, so the next transfer may land while a command is applied.
   plq_cmd_type cmd;

   // The controller sequences each command through a compare cycle, where
   // every resting entry's key is checked against the request, and an apply
   // cycle, where the oldest match is removed or the tail is written.
   plq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // The datapath holds the entries in arrival order as a row of registers
   // with the count and running total, and registers the result.
   plq_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

>>> hw/rtl/plq_checker.sv
module plq_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input plq_pkg::plq_req_type req_data,
   input logic                 rsp_valid,
   input plq_pkg::plq_rsp_type rsp_data
);
   import plq_pkg::*;

   // An accepted transfer always enters the compare cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transfer did not raise busy");

   // Every result follows the compare cycle, with busy high, of an accepted transfer.
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy, 2))
      else $error("result without a matching transfer");

   // A refused add only happens with the queue full.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_FULL) |->
         (rsp_data.level_count == LEVEL_CNT_W'(DEPTH)))
      else $error("full status with room left");

   // A failed command (not found or full) returns a zero key and quantity.
   a_removed_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_DONE) |->
         (rsp_data.removed_key == '0 && rsp_data.removed_qty == '0))
      else $error("removed fields set on a failed command");

   // An add of a transfer never reports a missing key; its strobed result is checked.
   a_add_status: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.opcode == OP_ADD) |->
         ##3 (rsp_valid && rsp_data.status != ST_NOT_FOUND))
      else $error("add reported missing key");

endmodule

bind price_level_order_queue plq_checker u_plq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
